>>> rtl/mqae_pkg.sv
// mqae_pkg: types, opcodes, the probability table and the byte-out step of the
// binary adaptive arithmetic encoder.
// No dependencies.
package mqae_pkg;

   // Transaction opcodes
   localparam logic [1:0] OP_ENCODE  = 2'd0;
   localparam logic [1:0] OP_FLUSH   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_RENORM,
      ST_FLUSH_SHIFT,
      ST_FLUSH_MOVE,
      ST_FLUSH_LAST,
      ST_DONE
   } state_type;

   // One context entry: MPS sense and probability index
   typedef struct packed {
      logic       mps;
      logic [5:0] idx;
   } ctx_state_type;

   // Context memory write request
   typedef struct packed {
      logic          en;
      logic [5:0]    addr;
      ctx_state_type data;
   } ctx_wr_type;

   typedef struct packed {
      logic [15:0] qe;
      logic [5:0]  nmps;
      logic [5:0]  nlps;
      logic        sw;
   } qe_row_type;

   // Result of one byte-out step
   typedef struct packed {
      logic [7:0]  buf_val;
      logic [27:0] code;
      logic [3:0]  ct;
      logic [7:0]  out_byte;
   } move_type;

   function automatic qe_row_type qe_lookup(input logic [5:0] idx);
      qe_row_type r;
      case (idx)
         6'd0:  r = '{16'h5601, 6'd1,  6'd1,  1'b1};
         6'd1:  r = '{16'h3401, 6'd2,  6'd6,  1'b0};
         6'd2:  r = '{16'h1801, 6'd3,  6'd9,  1'b0};
         6'd3:  r = '{16'h0AC1, 6'd4,  6'd12, 1'b0};
         6'd4:  r = '{16'h0521, 6'd5,  6'd29, 1'b0};
         6'd5:  r = '{16'h0221, 6'd38, 6'd33, 1'b0};
         6'd6:  r = '{16'h5601, 6'd7,  6'd6,  1'b1};
         6'd7:  r = '{16'h5401, 6'd8,  6'd14, 1'b0};
         6'd8:  r = '{16'h4801, 6'd9,  6'd14, 1'b0};
         6'd9:  r = '{16'h3801, 6'd10, 6'd14, 1'b0};
         6'd10: r = '{16'h3001, 6'd11, 6'd17, 1'b0};
         6'd11: r = '{16'h2401, 6'd12, 6'd18, 1'b0};
         6'd12: r = '{16'h1C01, 6'd13, 6'd20, 1'b0};
         6'd13: r = '{16'h1601, 6'd29, 6'd21, 1'b0};
         6'd14: r = '{16'h5601, 6'd15, 6'd14, 1'b1};
         6'd15: r = '{16'h5401, 6'd16, 6'd14, 1'b0};
         6'd16: r = '{16'h5101, 6'd17, 6'd15, 1'b0};
         6'd17: r = '{16'h4801, 6'd18, 6'd16, 1'b0};
         6'd18: r = '{16'h3801, 6'd19, 6'd17, 1'b0};
         6'd19: r = '{16'h3401, 6'd20, 6'd18, 1'b0};
         6'd20: r = '{16'h3001, 6'd21, 6'd19, 1'b0};
         6'd21: r = '{16'h2801, 6'd22, 6'd19, 1'b0};
         6'd22: r = '{16'h2401, 6'd23, 6'd20, 1'b0};
         6'd23: r = '{16'h2201, 6'd24, 6'd21, 1'b0};
         6'd24: r = '{16'h1C01, 6'd25, 6'd22, 1'b0};
         6'd25: r = '{16'h1801, 6'd26, 6'd23, 1'b0};
         6'd26: r = '{16'h1601, 6'd27, 6'd24, 1'b0};
         6'd27: r = '{16'h1401, 6'd28, 6'd25, 1'b0};
         6'd28: r = '{16'h1201, 6'd29, 6'd26, 1'b0};
         6'd29: r = '{16'h1101, 6'd30, 6'd27, 1'b0};
         6'd30: r = '{16'h0AC1, 6'd31, 6'd28, 1'b0};
         6'd31: r = '{16'h09C1, 6'd32, 6'd29, 1'b0};
         6'd32: r = '{16'h08A1, 6'd33, 6'd30, 1'b0};
         6'd33: r = '{16'h0521, 6'd34, 6'd31, 1'b0};
         6'd34: r = '{16'h0441, 6'd35, 6'd32, 1'b0};
         6'd35: r = '{16'h02A1, 6'd36, 6'd33, 1'b0};
         6'd36: r = '{16'h0221, 6'd37, 6'd34, 1'b0};
         6'd37: r = '{16'h0141, 6'd38, 6'd35, 1'b0};
         6'd38: r = '{16'h0111, 6'd39, 6'd36, 1'b0};
         6'd39: r = '{16'h0085, 6'd40, 6'd37, 1'b0};
         6'd40: r = '{16'h0049, 6'd41, 6'd38, 1'b0};
         6'd41: r = '{16'h0025, 6'd42, 6'd39, 1'b0};
         6'd42: r = '{16'h0015, 6'd43, 6'd40, 1'b0};
         6'd43: r = '{16'h0009, 6'd44, 6'd41, 1'b0};
         6'd44: r = '{16'h0005, 6'd45, 6'd42, 1'b0};
         6'd45: r = '{16'h0001, 6'd45, 6'd43, 1'b0};
         6'd46: r = '{16'h5601, 6'd46, 6'd46, 1'b0};
         // stored indexes never leave the table
         default: r = '{16'h5601, 6'd1, 6'd1, 1'b1};
      endcase
      return r;
   endfunction

   // Initial probability state of each context after a restart
   function automatic ctx_state_type ctx_init(input logic [5:0] addr);
      ctx_state_type s;
      s.mps = 1'b0;
      case (addr)
         6'd0:    s.idx = 6'd4;
         6'd9:    s.idx = 6'd3;
         6'd18:   s.idx = 6'd46;
         default: s.idx = 6'd0;
      endcase
      return s;
   endfunction

   // Byte-out with carry propagation and stuffing after 0xFF
   function automatic move_type move_byte(input logic [7:0] buf_val, input logic [27:0] code);
      move_type   m;
      logic [7:0] nb;
      logic [27:0] c;
      nb = buf_val + {7'd0, code[27]};
      c  = {1'b0, code[26:0]};
      if (buf_val == 8'hFF) begin
         m.out_byte = buf_val;
         m.buf_val  = code[27:20];
         m.code     = {8'd0, code[19:0]};
         m.ct       = 4'd7;
      end else if (nb == 8'hFF) begin
         m.out_byte = nb;
         m.buf_val  = c[27:20];
         m.code     = {8'd0, c[19:0]};
         m.ct       = 4'd7;
      end else begin
         m.out_byte = nb;
         m.buf_val  = c[26:19];
         m.code     = {9'd0, c[18:0]};
         m.ct       = 4'd8;
      end
      return m;
   endfunction

endpackage

>>> rtl/mqae_req_if.sv
// mqae_req_if: input channel of the encoder (valid/ready plus one command).
// No dependencies.
interface mqae_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [4:0] context_req;
   logic       bit_req;

   modport source (output valid, opcode, context_req, bit_req, input ready);
   modport sink   (input valid, opcode, context_req, bit_req, output ready);
endinterface

>>> rtl/mqae_rsp_if.sv
// mqae_rsp_if: result channel of the encoder (valid/ready plus one code byte).
// No dependencies.
interface mqae_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   logic       last_of_run;
   logic       final_byte;

   modport source (output valid, code_byte, last_of_run, final_byte, input ready);
   modport sink   (input valid, code_byte, last_of_run, final_byte, output ready);
endinterface

>>> rtl/mqae_ctx_mem.sv
// mqae_ctx_mem: context state memory with a registered read, and with valid
// bits so a restart returns every entry to its initial state at once.
// Depends on mqae_pkg.
module mqae_ctx_mem #(
   parameter int NUM_CONTEXTS = 19,
   parameter int ADDR_W       = 5
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output mqae_pkg::ctx_state_type rd_data,
   input  mqae_pkg::ctx_wr_type   wr
);

   mqae_pkg::ctx_state_type mem [NUM_CONTEXTS];
   mqae_pkg::ctx_state_type rd_data_ff;
   logic [NUM_CONTEXTS-1:0] valid_ff;
   logic                    rd_valid_ff;
   logic [ADDR_W-1:0]       rd_addr_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[ADDR_W-1:0]] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // valid bits: cleared by reset or restart
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr[ADDR_W-1:0]] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : mqae_pkg::ctx_init(6'(rd_addr_ff));

endmodule

>>> rtl/mq_arithmetic_encoder.sv
// mq_arithmetic_encoder: top level of the binary adaptive arithmetic encoder.
// Depends on mqae_pkg, mqae_req_if, mqae_rsp_if and mqae_ctx_mem.

// One transaction at a time. Restart, an unused opcode and an out-of-range
// context are handled in the idle state. An encode ends after the decision
// step when no renormalization is needed, otherwise it runs n interval shifts
// (one shift per cycle while the result side does not stall, at most 15) and
// a done step. A flush shifts the code, moves out the bytes and writes the
// last byte, then ends in the done step. The context is read from the memory
// port first. Result bytes pass through a one-byte holding stage and an
// output register; a byte is flagged last only when its transaction ends.
module mq_arithmetic_encoder #(
   parameter int NUM_CONTEXTS = 19
) (
   input  logic     clock,
   input  logic     reset,
   mqae_req_if.sink   req_chan,
   mqae_rsp_if.source rsp_chan
);

   localparam int ADDR_W = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

   mqae_pkg::state_type state_ff, state_in;

   logic [15:0] interval_ff, interval_in;
   logic [27:0] code_ff, code_in;
   logic [3:0]  ct_ff, ct_in;
   logic [7:0]  buf_ff, buf_in;
   logic        pending_ff, pending_in;
   logic        bit_ff;
   logic        flush_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [3:0]  guard_ff, guard_in;
   logic signed [4:0] nbits_ff, nbits_in;

   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  hold_byte_ff, hold_byte_in;
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;
   logic        out_final_ff, out_final_in;

   logic        req_fire;
   logic        in_range;
   logic [6:0]  ctx_ext;
   logic        out_free;
   logic        emit_req;
   logic [7:0]  emit_byte;
   logic        stall;
   logic        renorm_more;
   logic        flush_more;
   logic        restart;

   mqae_pkg::ctx_state_type ctx_rd;
   mqae_pkg::ctx_wr_type    ctx_wr;
   mqae_pkg::qe_row_type    row;
   mqae_pkg::move_type      mb;
   logic [15:0] a_sub;
   logic [15:0] intv_sh;
   logic [27:0] code_sh;
   logic [3:0]  ct_dec;

   // input handshake and decode
   assign req_chan.ready = (state_ff == mqae_pkg::ST_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign ctx_ext  = {2'b00, req_chan.context_req};
   assign in_range = ctx_ext < 7'(NUM_CONTEXTS);
   assign restart  = req_fire && (req_chan.opcode == mqae_pkg::OP_RESTART);

   mqae_ctx_mem #(
      .NUM_CONTEXTS (NUM_CONTEXTS),
      .ADDR_W       (ADDR_W)
   ) u_ctx_mem (
      .clock   (clock),
      .reset   (reset),
      .clear   (restart),
      .rd_en   (req_fire && (req_chan.opcode == mqae_pkg::OP_ENCODE) && in_range),
      .rd_addr (ctx_ext[ADDR_W-1:0]),
      .rd_data (ctx_rd),
      .wr      (ctx_wr)
   );

   // shared datapath pieces
   assign row      = mqae_pkg::qe_lookup(ctx_rd.idx);
   assign a_sub    = interval_ff - row.qe;
   assign intv_sh  = {interval_ff[14:0], 1'b0};
   assign code_sh  = {code_ff[26:0], 1'b0};
   assign ct_dec   = ct_ff - 4'd1;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      priority case (state_ff)
         mqae_pkg::ST_RENORM: mb = mqae_pkg::move_byte(buf_ff, code_sh);
         default:             mb = mqae_pkg::move_byte(buf_ff, code_ff);
      endcase
   end

   assign renorm_more = !intv_sh[15] && (guard_ff != 4'd15);
   assign flush_more  = (nbits_ff > 5'sd0) && !guard_ff[3];

   // byte request of the current step
   always_comb begin
      unique case (state_ff)
         mqae_pkg::ST_RENORM:     emit_req = (ct_dec == 4'd0);
         mqae_pkg::ST_FLUSH_MOVE: emit_req = flush_more;
         mqae_pkg::ST_FLUSH_LAST: emit_req = 1'b1;
         default:                 emit_req = 1'b0;
      endcase
   end
   assign emit_byte = mb.out_byte;
   assign stall = (emit_req && !pending_ff && hold_valid_ff && !out_free)
               || ((state_ff == mqae_pkg::ST_DONE) && hold_valid_ff && !out_free);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mqae_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.opcode == mqae_pkg::OP_ENCODE && in_range) begin
                  state_in = mqae_pkg::ST_DECIDE;
               end else if (req_chan.opcode == mqae_pkg::OP_FLUSH) begin
                  state_in = mqae_pkg::ST_FLUSH_SHIFT;
               end
            end
         end
         mqae_pkg::ST_DECIDE: begin
            if (ctx_rd.mps == bit_ff && a_sub[15]) begin
               state_in = mqae_pkg::ST_IDLE;
            end else begin
               state_in = mqae_pkg::ST_RENORM;
            end
         end
         mqae_pkg::ST_RENORM: begin
            if (!stall && !renorm_more) begin
               state_in = mqae_pkg::ST_DONE;
            end
         end
         mqae_pkg::ST_FLUSH_SHIFT: state_in = mqae_pkg::ST_FLUSH_MOVE;
         mqae_pkg::ST_FLUSH_MOVE: begin
            if (!flush_more) begin
               state_in = mqae_pkg::ST_FLUSH_LAST;
            end
         end
         mqae_pkg::ST_FLUSH_LAST: begin
            if (!stall) begin
               state_in = mqae_pkg::ST_DONE;
            end
         end
         mqae_pkg::ST_DONE: begin
            if (!stall) begin
               state_in = mqae_pkg::ST_IDLE;
            end
         end
         default: state_in = mqae_pkg::ST_IDLE;
      endcase
   end

   // coder datapath and context write-back
   always_comb begin
      interval_in = interval_ff;
      code_in     = code_ff;
      ct_in       = ct_ff;
      buf_in      = buf_ff;
      guard_in    = guard_ff;
      nbits_in    = nbits_ff;
      ctx_wr      = '0;
      ctx_wr.addr = 6'(addr_ff);
      unique case (state_ff)
         mqae_pkg::ST_IDLE: begin
            if (restart) begin
               interval_in = 16'h8000;
               code_in     = '0;
               ct_in       = 4'd12;
               buf_in      = '0;
            end
         end
         mqae_pkg::ST_DECIDE: begin
            guard_in = '0;
            interval_in = a_sub;
            if (ctx_rd.mps == bit_ff) begin
               if (a_sub[15]) begin
                  code_in = code_ff + {12'd0, row.qe};
               end else begin
                  if (a_sub < row.qe) begin
                     interval_in = row.qe;
                  end else begin
                     code_in = code_ff + {12'd0, row.qe};
                  end
                  ctx_wr.en       = 1'b1;
                  ctx_wr.data.mps = ctx_rd.mps;
                  ctx_wr.data.idx = row.nmps;
               end
            end else begin
               if (a_sub < row.qe) begin
                  code_in = code_ff + {12'd0, row.qe};
               end else begin
                  interval_in = row.qe;
               end
               ctx_wr.en       = 1'b1;
               ctx_wr.data.mps = ctx_rd.mps ^ row.sw;
               ctx_wr.data.idx = row.nlps;
            end
         end
         mqae_pkg::ST_RENORM: begin
            if (!stall) begin
               interval_in = intv_sh;
               guard_in    = guard_ff + 4'd1;
               if (emit_req) begin
                  code_in = mb.code;
                  ct_in   = mb.ct;
                  buf_in  = mb.buf_val;
               end else begin
                  code_in = code_sh;
                  ct_in   = ct_dec;
               end
            end
         end
         mqae_pkg::ST_FLUSH_SHIFT: begin
            code_in  = code_ff << ct_ff;
            nbits_in = 5'sd12 - $signed({1'b0, ct_ff});
            guard_in = '0;
         end
         mqae_pkg::ST_FLUSH_MOVE: begin
            if (flush_more && !stall) begin
               buf_in   = mb.buf_val;
               ct_in    = mb.ct;
               code_in  = mb.code << mb.ct;
               nbits_in = nbits_ff - $signed({1'b0, mb.ct});
               guard_in = guard_ff + 4'd1;
            end
         end
         mqae_pkg::ST_FLUSH_LAST: begin
            if (!stall) begin
               code_in = mb.code;
               ct_in   = mb.ct;
               buf_in  = '0;
            end
         end
         mqae_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // result path: holding stage and output register
   always_comb begin
      pending_in    = pending_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_final_in  = out_final_ff;
      if (restart) begin
         pending_in = 1'b1;
      end
      if (!stall) begin
         if (emit_req) begin
            if (pending_ff) begin
               pending_in = 1'b0;
            end else begin
               if (hold_valid_ff) begin
                  out_valid_in = 1'b1;
                  out_byte_in  = hold_byte_ff;
                  out_last_in  = 1'b0;
                  out_final_in = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_byte_in  = emit_byte;
            end
         end else if (state_ff == mqae_pkg::ST_DONE && hold_valid_ff) begin
            out_valid_in  = 1'b1;
            out_byte_in   = hold_byte_ff;
            out_last_in   = 1'b1;
            out_final_in  = flush_ff;
            hold_valid_in = 1'b0;
         end
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.code_byte   = out_byte_ff;
   assign rsp_chan.last_of_run = out_last_ff;
   assign rsp_chan.final_byte  = out_final_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mqae_pkg::ST_IDLE;
         interval_ff   <= 16'h8000;
         code_ff       <= '0;
         ct_ff         <= 4'd12;
         buf_ff        <= '0;
         pending_ff    <= 1'b1;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         guard_ff      <= '0;
         nbits_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         interval_ff   <= interval_in;
         code_ff       <= code_in;
         ct_ff         <= ct_in;
         buf_ff        <= buf_in;
         pending_ff    <= pending_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         guard_ff      <= guard_in;
         nbits_ff      <= nbits_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_byte_ff <= hold_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_final_ff <= out_final_in;
      if (req_fire) begin
         bit_ff   <= req_chan.bit_req;
         flush_ff <= (req_chan.opcode == mqae_pkg::OP_FLUSH);
         addr_ff  <= ctx_ext[ADDR_W-1:0];
      end
   end

`ifndef SYNTH
   // no byte is left in the holding stage between transactions
   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqae_pkg::ST_IDLE) |-> !hold_valid_ff)
      else $error("holding stage not empty in idle");

   // interval stays normalized between transactions
   a_interval_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqae_pkg::ST_IDLE) |-> interval_ff[15])
      else $error("interval not normalized in idle");

   // shift count stays in its working range between transactions
   a_ct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mqae_pkg::ST_IDLE) |-> (ct_ff != 4'd0 && ct_ff <= 4'd12))
      else $error("shift count out of range");

   // a final byte is always the last of its run
   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_final_ff) |-> out_last_ff)
      else $error("final byte not flagged last");
`endif

endmodule
